[sv/tsmp_pkg.sv]
// Shared types, codes and constants of the 2D texture sampler.
// Used by every module of the block but tsmp_ram; depends on nothing.
package tsmp_pkg;

    localparam int DEF_MAX_WIDTH  = 256;
    localparam int DEF_MAX_HEIGHT = 256;
    localparam int DEF_FRAC_BITS  = 16;

    localparam int ADDR_W     = 16;
    localparam int STORE_DEPTH = 1 << ADDR_W;
    localparam int CH_W       = 16;
    localparam int TEXEL_W    = 3 * CH_W;
    localparam int DIM_W      = 9;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 64;
    localparam int QUEUE_DEPTH = 4;

    typedef enum logic [0:0] {
        OP_LOAD   = 1'b0,
        OP_SAMPLE = 1'b1
    } opcode_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SAMPLE_MODE  = 3'd0,
        REG_IMAGE_WIDTH  = 3'd1,
        REG_IMAGE_HEIGHT = 3'd2,
        REG_COEF_ROW_U   = 3'd3,
        REG_COEF_ROW_V   = 3'd4,
        REG_OFFSET_UV    = 3'd5,
        REG_BORDER_COLOR = 3'd6
    } cfg_reg_t;

    localparam logic [1:0] WRAP_REPEAT = 2'd0;
    localparam logic [1:0] WRAP_EDGE   = 2'd1;
    localparam logic [1:0] WRAP_BORDER = 2'd2;

    // Decoded configuration, sizes already clamped to the supported range.
    typedef struct packed {
        logic [1:0]         wrap;
        logic               linear;
        logic [1:0]         chans;
        logic [DIM_W-1:0]   width;
        logic [DIM_W-1:0]   height;
        logic signed [31:0] m00;
        logic signed [31:0] m01;
        logic signed [31:0] m10;
        logic signed [31:0] m11;
        logic signed [31:0] tu;
        logic signed [31:0] tv;
        logic [TEXEL_W-1:0] border;
    } cfg_t;

    // One input beat after decoding.
    typedef struct packed {
        opcode_t            op;
        logic [ADDR_W-1:0]  index;
        logic [TEXEL_W-1:0] rgb;
        logic signed [31:0] u;
        logic signed [31:0] v;
    } item_t;

    // Texel request handed from the coordinate pipeline to the fetch stage.
    typedef struct packed {
        opcode_t            op;
        logic [ADDR_W-1:0]  index;
        logic [TEXEL_W-1:0] rgb;
        logic               border;
        logic [DIM_W-1:0]   x0;
        logic [DIM_W-1:0]   x1;
        logic [DIM_W-1:0]   y0;
        logic [DIM_W-1:0]   y1;
    } req_t;

    // Saturate a wide signed sum to the signed 32-bit range.
    function automatic logic signed [31:0] sat32(input logic signed [65:0] x);
        logic signed [31:0] r;
        if (x > 66'sd2147483647) begin
            r = 32'sh7FFFFFFF;
        end else if (x < -66'sd2147483648) begin
            r = 32'sh80000000;
        end else begin
            r = x[31:0];
        end
        return r;
    endfunction

endpackage

[sv/texture_sampler_2d.sv]
// Top level of the 2D texture sampler: configuration registers, front end,
// coordinate pipeline and filter back end. Depends on tsmp_pkg and all tsmp_ modules.
//
// Usage:
//  s_ channel: each beat either loads one texel (s_tuser[0] = 0) into the store at
//  texel_index, or asks for one sample (s_tuser[0] = 1) at (u_coord, v_coord).
//  m_ channel: one beat per sample with the filtered color; loads give no beat.
//  Configuration is written through cfg_we / cfg_index / cfg_data while idle.
//  Throughput is one beat per cycle, loads and samples alike, while not stalled:
//  four copies of the texel store give the four corner reads of a bilinear
//  sample together. An accepted beat passes through the queue entry written at
//  the accepting edge, four coordinate stages, one store read, one horizontal
//  blend and the output register.
//  When m_tvalid is high and m_tready low the back end holds; the four-entry
//  input queue keeps taking beats until it is full, then s_tready drops.
//  Reset clears the queue and pipeline valid bits, sets the default configuration;
//  the texel store is not cleared and must be loaded before it is sampled.
module texture_sampler_2d import tsmp_pkg::*; #(
    parameter int MAX_WIDTH       = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT      = DEF_MAX_HEIGHT,
    parameter int COORD_FRAC_BITS = DEF_FRAC_BITS
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // texel_index[15:0], texel_red[31:16], texel_green[47:32], texel_blue[63:48],
    // u_coord[95:64], v_coord[127:96]
    input  logic [127:0]          s_tdata,
    // opcode[0]
    input  logic [0:0]            s_tuser,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // red[15:0], green[31:16], blue[47:32]
    output logic [47:0]           m_tdata,
    // used_border[0]
    output logic [0:0]            m_tuser
);

    logic [4:0]           sample_mode_reg;
    logic [DIM_W-1:0]     image_width_reg, image_height_reg;
    logic [63:0]          coef_row_u_reg, coef_row_v_reg, offset_uv_reg;
    logic [TEXEL_W-1:0]   border_color_reg;
    cfg_t                 cfg;
    logic                 adv;
    logic                 q_valid;
    item_t                q_item;
    logic                 c_valid;
    req_t                 c_req;
    logic [COORD_FRAC_BITS-1:0] c_fx, c_fy;

    // Configuration registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sample_mode_reg  <= '0;
            image_width_reg  <= DIM_W'(256);
            image_height_reg <= DIM_W'(256);
            coef_row_u_reg   <= 64'h0000_0000_0001_0000;
            coef_row_v_reg   <= 64'h0001_0000_0000_0000;
            offset_uv_reg    <= '0;
            border_color_reg <= '0;
        end else if (cfg_we) begin
            case (cfg_index)
                REG_SAMPLE_MODE:  sample_mode_reg  <= cfg_data[4:0];
                REG_IMAGE_WIDTH:  image_width_reg  <= cfg_data[DIM_W-1:0];
                REG_IMAGE_HEIGHT: image_height_reg <= cfg_data[DIM_W-1:0];
                REG_COEF_ROW_U:   coef_row_u_reg   <= cfg_data;
                REG_COEF_ROW_V:   coef_row_v_reg   <= cfg_data;
                REG_OFFSET_UV:    offset_uv_reg    <= cfg_data;
                REG_BORDER_COLOR: border_color_reg <= cfg_data[TEXEL_W-1:0];
                default: ;
            endcase
        end
    end

    // Decode the configuration; sizes of zero act as one, large sizes as the maximum.
    always_comb begin
        cfg.wrap   = sample_mode_reg[1:0];
        cfg.linear = sample_mode_reg[2];
        cfg.chans  = sample_mode_reg[4:3];
        if (image_width_reg == '0) begin
            cfg.width = DIM_W'(1);
        end else if (32'(image_width_reg) > MAX_WIDTH) begin
            cfg.width = DIM_W'(MAX_WIDTH);
        end else begin
            cfg.width = image_width_reg;
        end
        if (image_height_reg == '0) begin
            cfg.height = DIM_W'(1);
        end else if (32'(image_height_reg) > MAX_HEIGHT) begin
            cfg.height = DIM_W'(MAX_HEIGHT);
        end else begin
            cfg.height = image_height_reg;
        end
        cfg.m00    = $signed(coef_row_u_reg[31:0]);
        cfg.m01    = $signed(coef_row_u_reg[63:32]);
        cfg.m10    = $signed(coef_row_v_reg[31:0]);
        cfg.m11    = $signed(coef_row_v_reg[63:32]);
        cfg.tu     = $signed(offset_uv_reg[31:0]);
        cfg.tv     = $signed(offset_uv_reg[63:32]);
        cfg.border = border_color_reg;
    end

    // The back end moves whenever the output register is free or being drained.
    assign adv = !m_tvalid || m_tready;

    tsmp_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .pop       (adv),
        .out_valid (q_valid),
        .out_item  (q_item)
    );

    tsmp_coord #(
        .FRAC_BITS(COORD_FRAC_BITS)
    ) u_coord (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .adv       (adv),
        .in_valid  (q_valid),
        .in_item   (q_item),
        .cfg       (cfg),
        .out_valid (c_valid),
        .out_req   (c_req),
        .out_fx    (c_fx),
        .out_fy    (c_fy)
    );

    tsmp_filter #(
        .FRAC_BITS(COORD_FRAC_BITS)
    ) u_filter (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .adv      (adv),
        .in_valid (c_valid),
        .in_req   (c_req),
        .in_fx    (c_fx),
        .in_fy    (c_fy),
        .cfg      (cfg),
        .m_tvalid (m_tvalid),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    // The border flag only appears in clamp-to-border mode.
    a_border_mode: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[0] |-> cfg.wrap == WRAP_BORDER)
        else $error("border result outside clamp-to-border mode");

    // A single-channel image returns gray texels.
    a_gray: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser[0] && cfg.chans == 2'd0 |->
            m_tdata[31:16] == m_tdata[15:0] && m_tdata[47:32] == m_tdata[15:0])
        else $error("single-channel result is not replicated");

    // Nothing is delivered in the cycle after reset.
    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");

endmodule

[sv/tsmp_ram.sv]
// Generic single-write, single-read RAM with a registered read port.
// Depends on nothing; used for the texel store copies.
module tsmp_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 65536
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port and registered read port.
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

[sv/tsmp_front.sv]
// Front end: accepts input beats, decodes them and queues them for the back end.
// Depends on tsmp_pkg.
module tsmp_front import tsmp_pkg::*; (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [127:0] s_tdata,
    input  logic [0:0]   s_tuser,
    input  logic         pop,
    output logic         out_valid,
    output item_t        out_item
);

    localparam int PTR_W = $clog2(QUEUE_DEPTH);

    item_t              queue_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [PTR_W:0]     count_reg, count_next;
    logic               push, do_pop;
    item_t              in_item;

    // Unpack the beat into its fields.
    always_comb begin
        in_item.op    = opcode_t'(s_tuser[0]);
        in_item.index = s_tdata[15:0];
        in_item.rgb   = s_tdata[63:16];
        in_item.u     = $signed(s_tdata[95:64]);
        in_item.v     = $signed(s_tdata[127:96]);
    end

    assign s_tready  = (count_reg != (PTR_W+1)'(QUEUE_DEPTH));
    assign out_valid = (count_reg != '0);
    assign out_item  = queue_reg[rd_ptr_reg];
    assign push      = s_tvalid && s_tready;
    assign do_pop    = pop && out_valid;

    // Queue pointers and fill count.
    always_comb begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg + (PTR_W+1)'(push) - (PTR_W+1)'(do_pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            queue_reg[wr_ptr_reg] <= in_item;
        end
    end

endmodule

[sv/tsmp_coord.sv]
// Coordinate pipeline: affine transform, border test, scaling and index wrap.
// Depends on tsmp_pkg.
module tsmp_coord import tsmp_pkg::*; #(
    parameter int FRAC_BITS = DEF_FRAC_BITS
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 adv,
    input  logic                 in_valid,
    input  item_t                in_item,
    input  cfg_t                 cfg,
    output logic                 out_valid,
    output req_t                 out_req,
    output logic [FRAC_BITS-1:0] out_fx,
    output logic [FRAC_BITS-1:0] out_fy
);

    localparam int PW = 33 + DIM_W + 1;
    localparam int IW = PW - FRAC_BITS;
    localparam logic signed [32:0]   ONE  = 33'sd1 <<< FRAC_BITS;
    localparam logic signed [PW-1:0] HALF = PW'(1) <<< (FRAC_BITS - 1);

    logic               a_valid_reg, b_valid_reg, c_valid_reg, d_valid_reg;
    item_t              a_item_reg, b_item_reg, c_item_reg;
    logic signed [63:0] a_p00_reg, a_p01_reg, a_p10_reg, a_p11_reg;
    logic signed [31:0] b_tu_reg, b_tv_reg;
    logic signed [31:0] b_tu_next, b_tv_next;
    logic signed [PW-1:0] c_pu_reg, c_pv_reg, c_pu_next, c_pv_next;
    logic               c_border_reg, c_border_next;
    req_t               d_req_reg, d_req_next;
    logic [FRAC_BITS-1:0] d_fx_reg, d_fy_reg, d_fx_next, d_fy_next;

    logic               repeat_mode;
    assign repeat_mode = (cfg.wrap == WRAP_REPEAT);

    // Index wrap: repeat folds the range [-1, n] back into [0, n-1]; clamp otherwise.
    function automatic logic [DIM_W-1:0] wrap_idx(input logic signed [IW-1:0] i,
                                                  input logic [DIM_W-1:0] n,
                                                  input logic rep);
        logic signed [IW-1:0] nn;
        logic [DIM_W-1:0]     r;
        nn = $signed(IW'(n));
        if (rep) begin
            if (i < 0) begin
                r = n - 1'b1;
            end else if (i >= nn) begin
                r = '0;
            end else begin
                r = i[DIM_W-1:0];
            end
        end else begin
            if (i < 0) begin
                r = '0;
            end else if (i > nn - 1) begin
                r = n - 1'b1;
            end else begin
                r = i[DIM_W-1:0];
            end
        end
        return r;
    endfunction

    // Valid bits of the four stages.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
            d_valid_reg <= 1'b0;
        end else if (adv) begin
            a_valid_reg <= in_valid;
            b_valid_reg <= a_valid_reg;
            c_valid_reg <= b_valid_reg;
            d_valid_reg <= c_valid_reg;
        end
    end

    // Stage A: the four matrix products.
    always_ff @(posedge aclk) begin
        if (adv) begin
            a_item_reg <= in_item;
            a_p00_reg  <= $signed(cfg.m00) * $signed(in_item.u);
            a_p01_reg  <= $signed(cfg.m01) * $signed(in_item.v);
            a_p10_reg  <= $signed(cfg.m10) * $signed(in_item.u);
            a_p11_reg  <= $signed(cfg.m11) * $signed(in_item.v);
        end
    end

    // Stage B: floor of the row sums, translation and saturation.
    always_comb begin
        logic signed [64:0] sum_u, sum_v, sh_u, sh_v;
        logic signed [65:0] tot_u, tot_v;
        sum_u = $signed({a_p00_reg[63], a_p00_reg}) + $signed({a_p01_reg[63], a_p01_reg});
        sum_v = $signed({a_p10_reg[63], a_p10_reg}) + $signed({a_p11_reg[63], a_p11_reg});
        sh_u  = sum_u >>> FRAC_BITS;
        sh_v  = sum_v >>> FRAC_BITS;
        tot_u = $signed({sh_u[64], sh_u}) + $signed({{34{cfg.tu[31]}}, cfg.tu});
        tot_v = $signed({sh_v[64], sh_v}) + $signed({{34{cfg.tv[31]}}, cfg.tv});
        b_tu_next = sat32(tot_u);
        b_tv_next = sat32(tot_v);
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            b_item_reg <= a_item_reg;
            b_tu_reg   <= b_tu_next;
            b_tv_reg   <= b_tv_next;
        end
    end

    // Stage C: border test and scaling by the image size. In repeat mode only
    // the fraction matters, since whole periods drop out of the wrapped index.
    always_comb begin
        logic signed [32:0]      mu, mv;
        logic signed [DIM_W:0]   ws, hs;
        if (repeat_mode) begin
            mu = '0;
            mv = '0;
            mu[FRAC_BITS-1:0] = b_tu_reg[FRAC_BITS-1:0];
            mv[FRAC_BITS-1:0] = b_tv_reg[FRAC_BITS-1:0];
        end else begin
            mu = {b_tu_reg[31], b_tu_reg};
            mv = {b_tv_reg[31], b_tv_reg};
        end
        ws = $signed({1'b0, cfg.width});
        hs = $signed({1'b0, cfg.height});
        c_pu_next = mu * ws;
        c_pv_next = mv * hs;
        c_border_next = (cfg.wrap == WRAP_BORDER) &&
                        (b_tu_reg < 0 || b_tu_reg > ONE || b_tv_reg < 0 || b_tv_reg > ONE);
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            c_item_reg   <= b_item_reg;
            c_pu_reg     <= c_pu_next;
            c_pv_reg     <= c_pv_next;
            c_border_reg <= c_border_next;
        end
    end

    // Stage D: integer indices, wrap and filter weights.
    always_comb begin
        logic signed [PW-1:0] t_u, t_v;
        logic signed [IW-1:0] i_u, i_v;
        t_u = cfg.linear ? c_pu_reg - HALF : c_pu_reg;
        t_v = cfg.linear ? c_pv_reg - HALF : c_pv_reg;
        i_u = $signed(t_u[PW-1:FRAC_BITS]);
        i_v = $signed(t_v[PW-1:FRAC_BITS]);
        d_req_next.op     = c_item_reg.op;
        d_req_next.index  = c_item_reg.index;
        d_req_next.rgb    = c_item_reg.rgb;
        d_req_next.border = c_border_reg;
        d_req_next.x0     = wrap_idx(i_u, cfg.width, repeat_mode);
        d_req_next.x1     = wrap_idx(i_u + $signed(IW'(1)), cfg.width, repeat_mode);
        d_req_next.y0     = wrap_idx(i_v, cfg.height, repeat_mode);
        d_req_next.y1     = wrap_idx(i_v + $signed(IW'(1)), cfg.height, repeat_mode);
        d_fx_next = cfg.linear ? t_u[FRAC_BITS-1:0] : '0;
        d_fy_next = cfg.linear ? t_v[FRAC_BITS-1:0] : '0;
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            d_req_reg <= d_req_next;
            d_fx_reg  <= d_fx_next;
            d_fy_reg  <= d_fy_next;
        end
    end

    assign out_valid = d_valid_reg;
    assign out_req   = d_req_reg;
    assign out_fx    = d_fx_reg;
    assign out_fy    = d_fy_reg;

endmodule

[sv/tsmp_filter.sv]
// Back end: texel store with four read copies, bilinear blend and output register.
// Depends on tsmp_pkg and tsmp_ram.
module tsmp_filter import tsmp_pkg::*; #(
    parameter int FRAC_BITS = DEF_FRAC_BITS
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 adv,
    input  logic                 in_valid,
    input  req_t                 in_req,
    input  logic [FRAC_BITS-1:0] in_fx,
    input  logic [FRAC_BITS-1:0] in_fy,
    input  cfg_t                 cfg,
    output logic                 m_tvalid,
    output logic [47:0]          m_tdata,
    output logic [0:0]           m_tuser
);

    localparam logic [FRAC_BITS:0] ONE  = (FRAC_BITS+1)'(1) << FRAC_BITS;
    localparam logic [FRAC_BITS:0] HALF = (FRAC_BITS+1)'(1) << (FRAC_BITS - 1);

    logic [ADDR_W-1:0]    raddr [4];
    logic [TEXEL_W-1:0]   rdata [4];
    logic                 we;
    logic                 f_valid_reg, g_valid_reg, m_valid_reg;
    logic                 f_border_reg, g_border_reg, m_border_reg;
    logic [FRAC_BITS-1:0] f_fx_reg, f_fy_reg, g_fy_reg;
    logic [TEXEL_W-1:0]   g_top_reg, g_bot_reg, g_top_next, g_bot_next;
    logic [TEXEL_W-1:0]   m_rgb_reg, m_rgb_next;

    // Row-major texel address, low bits only.
    function automatic logic [ADDR_W-1:0] texel_addr(input logic [DIM_W-1:0] x,
                                                     input logic [DIM_W-1:0] y,
                                                     input logic [DIM_W-1:0] w);
        logic [2*DIM_W:0] a;
        a = (2*DIM_W+1)'(y * w) + (2*DIM_W+1)'(x);
        return ADDR_W'(a);
    endfunction

    // Channel replication of one stored texel.
    function automatic logic [TEXEL_W-1:0] expand(input logic [TEXEL_W-1:0] t,
                                                  input logic [1:0] chans);
        logic [CH_W-1:0] r, g, b;
        r = t[CH_W-1:0];
        g = (chans >= 2'd1) ? t[2*CH_W-1:CH_W] : r;
        b = (chans >= 2'd2) ? t[3*CH_W-1:2*CH_W] : r;
        return {b, g, r};
    endfunction

    // One linear blend with round half up.
    function automatic logic [CH_W-1:0] blend(input logic [CH_W-1:0] a,
                                              input logic [CH_W-1:0] b,
                                              input logic [FRAC_BITS-1:0] f);
        logic [CH_W+FRAC_BITS+1:0] acc;
        acc = (CH_W+FRAC_BITS+2)'(a * (ONE - {1'b0, f}))
            + (CH_W+FRAC_BITS+2)'(b * f)
            + (CH_W+FRAC_BITS+2)'(HALF);
        return acc[CH_W+FRAC_BITS-1:FRAC_BITS];
    endfunction

    // Stage E: addresses of the four corner texels; loads write every copy.
    assign raddr[0] = texel_addr(in_req.x0, in_req.y0, cfg.width);
    assign raddr[1] = texel_addr(in_req.x1, in_req.y0, cfg.width);
    assign raddr[2] = texel_addr(in_req.x0, in_req.y1, cfg.width);
    assign raddr[3] = texel_addr(in_req.x1, in_req.y1, cfg.width);
    assign we       = adv && in_valid && (in_req.op == OP_LOAD);

    for (genvar k = 0; k < 4; k++) begin : g_store
        tsmp_ram #(
            .WIDTH(TEXEL_W),
            .DEPTH(STORE_DEPTH)
        ) u_ram (
            .aclk  (aclk),
            .we    (we),
            .waddr (in_req.index),
            .wdata (in_req.rgb),
            .re    (adv),
            .raddr (raddr[k]),
            .rdata (rdata[k])
        );
    end

    // Valid bits; only samples go on past the store.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            f_valid_reg <= 1'b0;
            g_valid_reg <= 1'b0;
            m_valid_reg <= 1'b0;
        end else if (adv) begin
            f_valid_reg <= in_valid && (in_req.op == OP_SAMPLE);
            g_valid_reg <= f_valid_reg;
            m_valid_reg <= g_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            f_border_reg <= in_req.border;
            f_fx_reg     <= in_fx;
            f_fy_reg     <= in_fy;
        end
    end

    // Stage F: horizontal blends of the top and bottom texel pairs.
    always_comb begin
        logic [TEXEL_W-1:0] ta, tb, tc, td;
        ta = expand(rdata[0], cfg.chans);
        tb = expand(rdata[1], cfg.chans);
        tc = expand(rdata[2], cfg.chans);
        td = expand(rdata[3], cfg.chans);
        for (int k = 0; k < 3; k++) begin
            g_top_next[k*CH_W +: CH_W] = blend(ta[k*CH_W +: CH_W], tb[k*CH_W +: CH_W], f_fx_reg);
            g_bot_next[k*CH_W +: CH_W] = blend(tc[k*CH_W +: CH_W], td[k*CH_W +: CH_W], f_fx_reg);
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            g_top_reg    <= g_top_next;
            g_bot_reg    <= g_bot_next;
            g_fy_reg     <= f_fy_reg;
            g_border_reg <= f_border_reg;
        end
    end

    // Stage G: vertical blend, or the border color, into the output register.
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            m_rgb_next[k*CH_W +: CH_W] = blend(g_top_reg[k*CH_W +: CH_W],
                                               g_bot_reg[k*CH_W +: CH_W], g_fy_reg);
        end
        if (g_border_reg) begin
            m_rgb_next = cfg.border;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            m_rgb_reg    <= m_rgb_next;
            m_border_reg <= g_border_reg;
        end
    end

    assign m_tvalid   = m_valid_reg;
    assign m_tdata    = m_rgb_reg;
    assign m_tuser[0] = m_border_reg;

endmodule

[dv/tb_texture_sampler_2d.sv]
// Self-checking testbench for the 2D texture sampler: loads texels, samples them under
// many configurations and checks every result against an in-bench color predictor.
// Depends on tsmp_pkg and texture_sampler_2d.
`timescale 1ns / 1ps

module tb_texture_sampler_2d;
    import tsmp_pkg::*;

    localparam int  CYCLE_LIMIT  = 400000;
    localparam int  DRAIN_CYCLES = 16;
    localparam int  NUM_PHASES   = 32;
    localparam longint ONE       = 64'sd65536;

    typedef struct {
        opcode_t     op;
        logic [15:0] index;
        logic [47:0] rgb;
        logic [31:0] u;
        logic [31:0] v;
    } beat_t;

    typedef struct {
        logic [47:0] color;
        logic        border;
    } color_t;

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [127:0]          s_tdata = '0;
    logic [0:0]            s_tuser = '0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [47:0]           m_tdata;
    logic [0:0]            m_tuser;

    // Predictor copy of the configuration and the texel store.
    logic [4:0]  mode_q   = 5'd0;
    logic [8:0]  width_q  = 9'd256;
    logic [8:0]  height_q = 9'd256;
    logic [63:0] row_u_q  = 64'd65536;
    logic [63:0] row_v_q  = 64'd281474976710656;
    logic [63:0] offset_q = 64'd0;
    logic [47:0] border_q = 48'd0;
    logic [47:0] texels [0:65535];

    beat_t  pending_beats[$];
    color_t expected_colors[$];

    bit     s_accepted = 1'b0;
    bit     m_accepted = 1'b0;
    bit     back_to_back = 1'b0;
    bit     hold_req = 1'b0;
    bit     hold_done = 1'b0;
    int     gap_left = 0;
    int     stall_left = 0;
    int     hold_left = 0;
    int     errors = 0;
    int     cycles = 0;
    int     samples_checked = 0;
    int     loads_sent = 0;
    int     border_hits = 0;

    texture_sampler_2d i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    always #6 aclk = ~aclk;

    // Effective image sizes after clamping to 1..256.
    function automatic longint eff_size(input logic [8:0] n);
        longint r;
        r = longint'(n);
        if (r < 1) r = 1;
        if (r > 256) r = 256;
        return r;
    endfunction

    // One row of the affine transform with exact floor and signed 32-bit saturation.
    function automatic longint map_row(input logic [63:0] row, input logic [31:0] off,
                                       input longint u, input longint v);
        longint p0, p1, s;
        p0 = longint'($signed(row[31:0])) * u;
        p1 = longint'($signed(row[63:32])) * v;
        s = (p0 >>> 16) + (p1 >>> 16)
            + (longint'((p0 & 64'hFFFF) + (p1 & 64'hFFFF)) >>> 16)
            + longint'($signed(off));
        if (s > 64'sd2147483647) s = 64'sd2147483647;
        if (s < -64'sd2147483648) s = -64'sd2147483648;
        return s;
    endfunction

    function automatic longint wrap_idx(input longint i, input longint n, input bit rep);
        if (rep) return ((i % n) + n) % n;
        if (i < 0) return 0;
        if (i > n - 1) return n - 1;
        return i;
    endfunction

    // Read one texel and replicate red into the channels the image does not have.
    function automatic logic [47:0] read_texel(input longint x, input longint y,
                                               input longint w);
        logic [47:0] t;
        logic [15:0] r, g, b;
        t = texels[16'((y * w + x) & 64'hFFFF)];
        r = t[15:0];
        g = (mode_q[4:3] >= 2'd1) ? t[31:16] : r;
        b = (mode_q[4:3] >= 2'd2) ? t[47:32] : r;
        return {b, g, r};
    endfunction

    function automatic longint lerp(input longint a, input longint b, input longint f);
        return (a * (ONE - f) + b * f + (ONE >> 1)) >>> 16;
    endfunction

    function automatic color_t predict_color(input logic [31:0] u_in, input logic [31:0] v_in);
        color_t res;
        longint u, v, tu, tv, w, h, sx, sy, x0, x1, y0, y1, fx, fy, top, bot;
        logic [47:0] a, b, c, d;
        bit rep;
        u = longint'($signed(u_in));
        v = longint'($signed(v_in));
        tu = map_row(row_u_q, offset_q[31:0], u, v);
        tv = map_row(row_v_q, offset_q[63:32], u, v);
        w = eff_size(width_q);
        h = eff_size(height_q);
        rep = (mode_q[1:0] == WRAP_REPEAT);
        res.border = 1'b0;
        if (mode_q[1:0] == WRAP_BORDER && (tu < 0 || tu > ONE || tv < 0 || tv > ONE)) begin
            res.color = border_q;
            res.border = 1'b1;
        end else if (!mode_q[2]) begin
            res.color = read_texel(wrap_idx((tu * w) >>> 16, w, rep),
                                   wrap_idx((tv * h) >>> 16, h, rep), w);
        end else begin
            sx = tu * w - (ONE >> 1);
            sy = tv * h - (ONE >> 1);
            fx = sx & 64'hFFFF;
            fy = sy & 64'hFFFF;
            x0 = wrap_idx(sx >>> 16, w, rep);
            x1 = wrap_idx((sx >>> 16) + 1, w, rep);
            y0 = wrap_idx(sy >>> 16, h, rep);
            y1 = wrap_idx((sy >>> 16) + 1, h, rep);
            a = read_texel(x0, y0, w);
            b = read_texel(x1, y0, w);
            c = read_texel(x0, y1, w);
            d = read_texel(x1, y1, w);
            for (int k = 0; k < 3; k++) begin
                top = lerp(longint'(a[16*k +: 16]), longint'(b[16*k +: 16]), fx);
                bot = lerp(longint'(c[16*k +: 16]), longint'(d[16*k +: 16]), fx);
                res.color[16*k +: 16] = 16'(lerp(top, bot, fy));
            end
        end
        return res;
    endfunction

    // Rising edge: record handshakes, predict accepted samples, check results.
    always @(posedge aclk) begin
        color_t exp_c;
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
        s_accepted <= s_tvalid && s_tready;
        m_accepted <= m_tvalid && m_tready;
        if (aresetn && s_tvalid && s_tready) begin
            if (s_tuser[0] == OP_LOAD) begin
                texels[s_tdata[15:0]] = s_tdata[63:16];
            end else begin
                expected_colors.push_back(predict_color(s_tdata[95:64], s_tdata[127:96]));
            end
        end
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_colors.size() == 0) begin
                $error("result beat with no sample outstanding: %h", m_tdata);
                errors++;
            end else begin
                exp_c = expected_colors.pop_front();
                samples_checked++;
                if (exp_c.border) border_hits++;
                if (m_tdata[15:0] !== exp_c.color[15:0]) begin
                    $error("red: expected %h, actual %h", exp_c.color[15:0], m_tdata[15:0]);
                    errors++;
                end
                if (m_tdata[31:16] !== exp_c.color[31:16]) begin
                    $error("green: expected %h, actual %h", exp_c.color[31:16], m_tdata[31:16]);
                    errors++;
                end
                if (m_tdata[47:32] !== exp_c.color[47:32]) begin
                    $error("blue: expected %h, actual %h", exp_c.color[47:32], m_tdata[47:32]);
                    errors++;
                end
                if (m_tuser[0] !== exp_c.border) begin
                    $error("used_border: expected %0d, actual %0d", exp_c.border, m_tuser[0]);
                    errors++;
                end
            end
        end
    end

    // Input driver: presents queued beats with random gaps.
    always @(negedge aclk) begin
        beat_t bt;
        if (aresetn && !(s_tvalid && !s_accepted)) begin
            if (gap_left > 0) begin
                s_tvalid <= 1'b0;
                gap_left <= gap_left - 1;
            end else if (pending_beats.size() > 0) begin
                bt = pending_beats.pop_front();
                s_tdata  <= {bt.v, bt.u, bt.rgb, bt.index};
                s_tuser  <= bt.op;
                s_tvalid <= 1'b1;
                gap_left <= back_to_back ? 0 : $urandom_range(0, 4);
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // Long hold-off of the receiver, counted down once per cycle.
    always @(negedge aclk) begin
        if (!aresetn) begin
            hold_left <= 0;
        end else if (hold_req && !hold_done) begin
            hold_left <= 300;
            hold_done <= 1'b1;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
        end
    end

    // Result receiver: random stalls after each beat, held off during the long stretch.
    always @(negedge aclk) begin
        int draw;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if ((hold_req && !hold_done) || hold_left > 0) begin
            m_tready <= 1'b0;
        end else if (m_accepted) begin
            draw = back_to_back ? 0 : $urandom_range(0, 4);
            stall_left <= draw;
            m_tready   <= (draw == 0);
        end else if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            m_tready   <= (stall_left == 1);
        end else begin
            m_tready <= 1'b1;
        end
    end

    task automatic write_reg(input cfg_reg_t idx, input logic [63:0] value);
        @(negedge aclk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        case (idx)
            REG_SAMPLE_MODE:  mode_q   = value[4:0];
            REG_IMAGE_WIDTH:  width_q  = value[8:0];
            REG_IMAGE_HEIGHT: height_q = value[8:0];
            REG_COEF_ROW_U:   row_u_q  = value;
            REG_COEF_ROW_V:   row_v_q  = value;
            REG_OFFSET_UV:    offset_q = value;
            default:          border_q = value[47:0];
        endcase
        @(negedge aclk);
        cfg_we <= 1'b0;
    endtask

    task automatic wait_idle();
        while (pending_beats.size() != 0 || s_tvalid || expected_colors.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(negedge aclk);
    endtask

    task automatic push_load(input logic [15:0] idx, input logic [47:0] rgb);
        beat_t bt;
        bt.op = OP_LOAD;
        bt.index = idx;
        bt.rgb = rgb;
        bt.u = $urandom;
        bt.v = $urandom;
        pending_beats.push_back(bt);
        loads_sent++;
    endtask

    task automatic push_sample(input logic [31:0] u, input logic [31:0] v);
        beat_t bt;
        bt.op = OP_SAMPLE;
        bt.index = 16'($urandom);
        bt.rgb = 48'({$urandom, $urandom});
        bt.u = u;
        bt.v = v;
        pending_beats.push_back(bt);
    endtask

    // Mostly coordinates in [-1, 2], sometimes anywhere in the 32-bit range.
    function automatic logic [31:0] rand_coord();
        if ($urandom_range(0, 9) == 0) return $urandom;
        return 32'($urandom_range(0, 3 * 65536)) - 32'd65536;
    endfunction

    function automatic logic [63:0] rand_row(input bit u_row);
        logic [31:0] a, b;
        case ($urandom_range(0, 4))
            0: return u_row ? 64'h0000_0000_0001_0000 : 64'h0001_0000_0000_0000;
            1: return {$urandom, $urandom};
            default: begin
                a = 32'($urandom_range(0, 4 * 65536)) - 32'h0002_0000;
                b = 32'($urandom_range(0, 65536)) - 32'h0000_8000;
                return u_row ? {b, a} : {a, b};
            end
        endcase
    endfunction

    initial begin
        logic [8:0]  w_cfg, h_cfg;
        logic [63:0] off;
        longint      area;
        int          n_items;

        repeat (6) @(negedge aclk);
        aresetn <= 1'b1;

        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            // Image size: small most of the time, extremes and out-of-range values in a few.
            case (ph)
                1: begin w_cfg = 9'd0;   h_cfg = 9'd0;   end
                2: begin w_cfg = 9'd511; h_cfg = 9'd1;   end
                6: begin w_cfg = 9'd1;   h_cfg = 9'd300 - 9'd44; end
                9: begin w_cfg = 9'd1;   h_cfg = 9'd400; end
                default: begin
                    w_cfg = 9'($urandom_range(1, 6));
                    h_cfg = 9'($urandom_range(1, 6));
                end
            endcase
            off = ($urandom_range(0, 7) == 0) ? {$urandom, $urandom} :
                  {32'($urandom_range(0, 65536)) - 32'h8000,
                   32'($urandom_range(0, 65536)) - 32'h8000};
            if (ph == 0) off = 64'd0;
            write_reg(REG_SAMPLE_MODE, 64'((ph * 7 + 2) % 32));
            write_reg(REG_IMAGE_WIDTH, 64'(w_cfg));
            write_reg(REG_IMAGE_HEIGHT, 64'(h_cfg));
            write_reg(REG_COEF_ROW_U, ph == 0 ? 64'h0000_0000_0001_0000 : rand_row(1'b1));
            write_reg(REG_COEF_ROW_V, ph == 0 ? 64'h0001_0000_0000_0000 : rand_row(1'b0));
            write_reg(REG_OFFSET_UV, off);
            write_reg(REG_BORDER_COLOR, ph == 0 ? 64'hFFFF_0000_FFFF : {$urandom, $urandom});

            back_to_back = (ph % 5 == 4);
            if (ph == 3) hold_req = 1'b1;

            // Fill every texel the image can address before any sample reads it.
            area = eff_size(w_cfg) * eff_size(h_cfg);
            for (longint i = 0; i < area; i++) begin
                if (ph == 0 && i == 0) push_load(16'(i), 48'h0);
                else if (ph == 0 && i == 1) push_load(16'(i), 48'hFFFF_FFFF_FFFF);
                else push_load(16'(i), 48'({$urandom, $urandom}));
            end

            if (ph == 0) begin
                // Corners, edges, the exact 1.0 boundary and saturating coordinates.
                push_sample(32'h0, 32'h0);
                push_sample(32'h0001_0000, 32'h0001_0000);
                push_sample(32'h0000_8000, 32'h0000_4000);
                push_sample(32'hFFFF_FFFF, 32'h0000_0001);
                push_sample(32'h7FFF_FFFF, 32'h8000_0000);
                push_sample(32'h8000_0000, 32'h7FFF_FFFF);
                push_sample(32'h0001_0001, 32'h0);
                push_sample(32'hFFFF_0000, 32'h0002_8000);
                push_load(16'hFFFF, 48'hAAAA_5555_AAAA);
            end

            n_items = (ph == 3) ? 60 : 12;
            for (int k = 0; k < n_items; k++) begin
                case ($urandom_range(0, 19))
                    0:       push_load(16'($urandom), 48'({$urandom, $urandom}));
                    1, 2, 3: push_load(16'($urandom_range(0, int'(area) - 1)),
                                       48'({$urandom, $urandom}));
                    default: push_sample(rand_coord(), rand_coord());
                endcase
            end
            wait_idle();
        end

        $display("Checked %0d samples (%0d with border) after %0d texel loads,",
                 samples_checked, border_hits, loads_sent);
        $display("over %0d configurations of mode, size, transform and border.", NUM_PHASES);
        if (errors == 0 && expected_colors.size() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

[texture_sampler_2d.f]
sv/tsmp_pkg.sv
sv/tsmp_ram.sv
sv/tsmp_front.sv
sv/tsmp_coord.sv
sv/tsmp_filter.sv
sv/texture_sampler_2d.sv
dv/tb_texture_sampler_2d.sv
